### src/gbr_pkg.sv
// Shared types and constants for the reflect-border Gaussian blur.
`timescale 1ns / 1ps
package gbr_pkg;

  localparam int MAX_TAPS  = 5;   // window taps per column at the largest radius
  localparam int COL_BITS  = 12;  // column index at the largest line length
  localparam int WID_BITS  = 13;  // line length up to the largest line length
  localparam int PIX_W     = 8;
  localparam int WGT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SIZE_W    = 11;
  localparam int NUM_WGT   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_W0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_W1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_W2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_W0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_W1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_W2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd7;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WGT_W-1:0] wgt_t;

  // One window column handed from the front end to the arithmetic back end
  typedef struct packed {
    logic                      emit;       // this column produces output words
    logic                      frame_end;  // column belongs to the last drain row
    logic [COL_BITS-1:0]       col;        // column index in use
    logic [WID_BITS-1:0]       width;      // line length in use
    pix_t [MAX_TAPS-1:0]       taps;       // new column, top row first
  } gbr_cmd_t;

endpackage

### src/gbr_fifo.sv
// Four-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
module gbr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  gbr_pkg::gbr_cmd_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output gbr_pkg::gbr_cmd_t rd_data,
  output logic              empty
);
  import gbr_pkg::*;

  gbr_cmd_t    mem_r [4];
  logic [1:0]  wptr_r;
  logic [1:0]  rptr_r;
  logic [2:0]  cnt_r;
  logic        do_wr;
  logic        do_rd;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 2'd0;
      rptr_r <= 2'd0;
      cnt_r  <= 3'd0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + 2'd1;
      if (do_rd) rptr_r <= rptr_r + 2'd1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 3'd1;
      else if (!do_wr && do_rd) cnt_r <= cnt_r - 3'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr_data;
  end

endmodule

### src/gbr_front.sv
// Front end: position counters, border mirroring, line store and column assembly.
`timescale 1ns / 1ps
module gbr_front #(
  parameter int RADIUS    = 2,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  gbr_pkg::pix_t              in_pixel_in,
  input  logic [gbr_pkg::SIZE_W-1:0] frame_width,
  input  logic [gbr_pkg::SIZE_W-1:0] frame_height,
  output logic                       cmd_push,
  output gbr_pkg::gbr_cmd_t          cmd,
  input  logic                       cmd_full
);
  import gbr_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int TAPS  = 2 * RADIUS + 1;
  localparam int SLOTS = 2 * RADIUS;
  localparam int SB    = $clog2(SLOTS);
  localparam int SW    = SIZE_W + 2;  // signed row arithmetic

  logic [CW-1:0]     col_r;
  logic [SIZE_W-1:0] row_r;

  logic [12:0]       wv;
  logic [12:0]       wm1;
  logic [SIZE_W-1:0] hv;
  logic [SIZE_W-1:0] hm1;
  logic [SIZE_W-1:0] hl;
  logic              drain;
  logic [CW-1:0]     c;
  logic [SIZE_W-1:0] r;
  logic              accept;
  logic              act;
  logic              shift;
  logic              emit;
  logic              fend;
  logic [SB-1:0]     slot   [TAPS];
  logic              usepix [TAPS];

  // stage registers
  logic              stg_v_r;
  logic [SB-1:0]     slot_r   [TAPS];
  logic              usepix_r [TAPS];
  pix_t              pix_r;
  logic              emit_r;
  logic              fend_r;
  logic [CW-1:0]     c_r;
  logic [12:0]       w_r;
  pix_t              rd_r [SLOTS];

  // sizes in use
  always_comb begin
    if ({2'b00, frame_width} < 13'(RADIUS + 1)) wv = 13'(RADIUS + 1);
    else if ({2'b00, frame_width} > 13'(MAX_WIDTH)) wv = 13'(MAX_WIDTH);
    else wv = {2'b00, frame_width};
    if (frame_height < SIZE_W'(RADIUS + 1)) hv = SIZE_W'(RADIUS + 1);
    else if (frame_height > SIZE_W'(1024)) hv = SIZE_W'(1024);
    else hv = frame_height;
  end

  assign wm1   = wv - 13'd1;
  assign hm1   = hv - 11'd1;
  assign hl    = hv + SIZE_W'(RADIUS - 1);
  assign drain = (row_r >= hv);

  // position in use
  always_comb begin
    if ({{(13 - CW){1'b0}}, col_r} > wm1) c = wm1[CW-1:0];
    else c = col_r;
    if (drain && row_r > hl) r = hl;
    else r = row_r;
  end

  assign in_stall = stg_v_r && cmd_full;
  assign accept   = in_valid && !in_stall;
  assign act      = accept && !(!drain && in_op);
  assign shift    = (r >= SIZE_W'(RADIUS));
  assign emit     = shift && (c >= CW'(RADIUS));
  assign fend     = drain && (r == hl);

  // mirrored source row of each tap
  always_comb begin
    logic signed [SW-1:0] p;
    logic        [SIZE_W-1:0] q;
    for (int a = 0; a < TAPS; a++) begin
      p = $signed({2'b00, r}) + SW'(a - 2 * RADIUS);
      if (p < 0) p = -p;
      if (p > $signed({2'b00, hm1})) p = $signed({1'b0, hm1, 1'b0}) - p;
      if (p < 0) p = '0;
      if (p > $signed({2'b00, hm1})) p = $signed({2'b00, hm1});
      q         = p[SIZE_W-1:0];
      slot[a]   = q[SB-1:0];
      usepix[a] = !drain && (q == r);
    end
  end

  // line store, one row per slot, read before write
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    pix_t mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (act) rd_r[s] <= mem[c];
      if (act && !drain && (r[SB-1:0] == SB'(s))) mem[c] <= in_pixel_in;
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (act) begin
      if ({{(13 - CW){1'b0}}, c} == wm1) begin
        col_r <= '0;
        row_r <= (r == hl) ? '0 : r + 11'd1;
      end else begin
        col_r <= c + CW'(1);
      end
    end
  end

  // stage register ahead of the queue
  always_ff @(posedge clk) begin
    if (!rst_n) stg_v_r <= 1'b0;
    else if (!in_stall) stg_v_r <= act && shift;
  end

  always_ff @(posedge clk) begin
    if (!in_stall && act) begin
      slot_r   <= slot;
      usepix_r <= usepix;
      pix_r    <= in_pixel_in;
      emit_r   <= emit;
      fend_r   <= fend;
      c_r      <= c;
      w_r      <= wv;
    end
  end

  // assemble the new column
  always_comb begin
    cmd           = '0;
    cmd.emit      = emit_r;
    cmd.frame_end = fend_r;
    cmd.col       = COL_BITS'(c_r);
    cmd.width     = w_r;
    for (int a = 0; a < TAPS; a++) begin
      cmd.taps[a] = usepix_r[a] ? pix_r : rd_r[slot_r[a]];
    end
  end

  assign cmd_push = stg_v_r && !cmd_full;

endmodule

### src/gbr_back.sv
// Back end: window of column sums and a shared multiply-accumulate unit.
`timescale 1ns / 1ps
module gbr_back #(
  parameter int RADIUS    = 2,
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gbr_pkg::gbr_cmd_t cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  gbr_pkg::wgt_t     vert_w  [gbr_pkg::NUM_WGT],
  input  gbr_pkg::wgt_t     horiz_w [gbr_pkg::NUM_WGT],
  output logic              out_valid,
  input  logic              out_stall,
  output gbr_pkg::pix_t     out_pixel_out,
  output logic              out_run_last,
  output logic              out_frame_last
);
  import gbr_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int TAPS = 2 * RADIUS + 1;
  localparam int KW   = $clog2(TAPS);
  localparam int VW   = WGT_W + PIX_W + 3;
  localparam int PW   = WGT_W + VW;
  localparam int AW   = PW + 3;
  localparam int QW   = CW + 3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_VERT = 4'b0010,
    ST_HORZ = 4'b0100,
    ST_OUT  = 4'b1000
  } back_state_t;

  back_state_t   state_r;
  gbr_cmd_t      cmd_r;
  logic [VW-1:0] win_r [TAPS];
  logic [KW-1:0] tap_r;
  logic [AW-1:0] acc_r;
  logic [CW-1:0] oc_r;
  logic [CW-1:0] last_r;
  logic          out_v_r;
  pix_t          res_r;
  logic          run_last_r;
  logic          frame_last_r;

  logic [KW-1:0] tap_dist;
  logic [WGT_W-1:0] m_a;
  logic [VW-1:0] m_b;
  logic [PW-1:0] prod;
  logic [AW-1:0] sum;
  logic [AW-1:0] rnd;
  pix_t          sat;
  logic [KW-1:0] k;
  logic [CW:0]   wm1;
  logic [CW-1:0] cmd_c;
  logic [CW:0]   cmd_wm1;
  logic          tap_end;

  assign tap_dist = (tap_r >= KW'(RADIUS)) ? tap_r - KW'(RADIUS) : KW'(RADIUS) - tap_r;
  assign wm1     = cmd_r.width[CW:0] - 1'b1;
  assign cmd_c   = cmd.col[CW-1:0];
  assign cmd_wm1 = cmd.width[CW:0] - 1'b1;
  assign tap_end = (tap_r == KW'(TAPS - 1));

  // window column picked for the current horizontal tap
  always_comb begin
    logic signed [QW-1:0] q;
    logic signed [QW-1:0] d;
    q = $signed({3'b000, oc_r}) + QW'(tap_r) - QW'(RADIUS);
    if (q < 0) q = -q;
    if (q > $signed({2'b00, wm1})) q = $signed({1'b0, wm1, 1'b0}) - q;
    if (q < 0) q = '0;
    if (q > $signed({2'b00, wm1})) q = $signed({2'b00, wm1});
    d = $signed({3'b000, cmd_r.col[CW-1:0]}) - q;
    if (d < 0) d = '0;
    if (d > QW'(2 * RADIUS)) d = QW'(2 * RADIUS);
    k = d[KW-1:0];
  end

  // shared multiplier
  always_comb begin
    if (state_r == ST_VERT) begin
      m_a = vert_w[tap_dist[1:0]];
      m_b = VW'(cmd_r.taps[tap_r]);
    end else begin
      m_a = horiz_w[tap_dist[1:0]];
      m_b = win_r[k];
    end
  end

  assign prod = m_a * m_b;
  assign sum  = acc_r + AW'(prod);
  assign rnd  = sum + (AW'(1) << 31);
  assign sat  = (rnd[AW-1:40] != '0) ? 8'hFF : rnd[39:32];

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
      for (int i = 0; i < TAPS; i++) win_r[i] <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!cmd_empty) begin
            cmd_r  <= cmd;
            oc_r   <= cmd_c - CW'(RADIUS);
            last_r <= ({1'b0, cmd_c} == cmd_wm1) ? cmd_wm1[CW-1:0] : cmd_c - CW'(RADIUS);
            tap_r  <= '0;
            acc_r  <= '0;
            state_r <= ST_VERT;
          end
        end
        ST_VERT: begin
          if (tap_end) begin
            for (int i = TAPS - 1; i > 0; i--) win_r[i] <= win_r[i-1];
            win_r[0] <= sum[VW-1:0];
            tap_r    <= '0;
            acc_r    <= '0;
            state_r  <= cmd_r.emit ? ST_HORZ : ST_IDLE;
          end else begin
            tap_r <= tap_r + KW'(1);
            acc_r <= sum;
          end
        end
        ST_HORZ: begin
          if (tap_end) begin
            res_r        <= sat;
            run_last_r   <= (oc_r == last_r);
            frame_last_r <= cmd_r.frame_end && ({1'b0, oc_r} == wm1);
            out_v_r      <= 1'b1;
            state_r      <= ST_OUT;
          end else begin
            tap_r <= tap_r + KW'(1);
            acc_r <= sum;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_v_r <= 1'b0;
            tap_r   <= '0;
            acc_r   <= '0;
            if (oc_r == last_r) begin
              state_r <= ST_IDLE;
            end else begin
              oc_r    <= oc_r + CW'(1);
              state_r <= ST_HORZ;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cmd_pop        = (state_r == ST_IDLE) && !cmd_empty;
  assign out_valid      = out_v_r;
  assign out_pixel_out  = res_r;
  assign out_run_last   = run_last_r;
  assign out_frame_last = frame_last_r;

endmodule

### src/gaussian_blur_reflect_border.sv
// Top level of the streaming reflect-border Gaussian blur.
`timescale 1ns / 1ps
// Usage:
//   Input words (in_op, in_pixel_in) arrive in raster order on a valid/stall
//   channel. in_op = 0 carries a frame pixel; after the frame, frame_width
//   times RADIUS words with in_op = 1 flush out the mirrored bottom rows.
//   Result words (out_pixel_out, out_run_last, out_frame_last) leave on a
//   valid/stall channel; out_run_last closes the words caused by one input,
//   out_frame_last marks the final pixel of a frame.
//   Configuration (weights, frame size) is written on cfg_wr_en/cfg_index/
//   cfg_wr_data while the block is idle.
// Timing:
//   The front end takes one word per cycle, unless in_stall is high, into a
//   four-entry column queue. The back end has one shared 16 x 27 multiplier:
//   each column gets a vertical sum over its 2*RADIUS+1 taps, and each result
//   word a horizontal sum over 2*RADIUS+1 window columns plus a handoff.
// Reset: synchronous, active low; counters, queue and window clear and the
//   weights and sizes return to their defaults. A stalled result holds the
//   back end; once the queue fills, in_stall rises.
module gaussian_blur_reflect_border #(
  parameter int RADIUS    = 2,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  gbr_pkg::pix_t                 in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gbr_pkg::pix_t                 out_pixel_out,
  output logic                          out_run_last,
  output logic                          out_frame_last,
  input  logic                          cfg_wr_en,
  input  logic [gbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbr_pkg::CFG_W-1:0]     cfg_wr_data
);
  import gbr_pkg::*;

  wgt_t              vert_w_r  [NUM_WGT];
  wgt_t              horiz_w_r [NUM_WGT];
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;

  gbr_cmd_t          push_cmd;
  gbr_cmd_t          pop_cmd;
  logic              cmd_push;
  logic              cmd_pop;
  logic              cmd_full;
  logic              cmd_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vert_w_r[0]  <= 16'd16474;
      vert_w_r[1]  <= 16'd14539;
      vert_w_r[2]  <= 16'd9992;
      horiz_w_r[0] <= 16'd16474;
      horiz_w_r[1] <= 16'd14539;
      horiz_w_r[2] <= 16'd9992;
      width_r      <= 11'd512;
      height_r     <= 11'd512;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_VERT_W0:  vert_w_r[0]  <= cfg_wr_data;
        CFG_VERT_W1:  vert_w_r[1]  <= cfg_wr_data;
        CFG_VERT_W2:  vert_w_r[2]  <= cfg_wr_data;
        CFG_HORIZ_W0: horiz_w_r[0] <= cfg_wr_data;
        CFG_HORIZ_W1: horiz_w_r[1] <= cfg_wr_data;
        CFG_HORIZ_W2: horiz_w_r[2] <= cfg_wr_data;
        CFG_WIDTH:    width_r      <= cfg_wr_data[SIZE_W-1:0];
        CFG_HEIGHT:   height_r     <= cfg_wr_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  gbr_front #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_pixel_in  (in_pixel_in),
    .frame_width  (width_r),
    .frame_height (height_r),
    .cmd_push     (cmd_push),
    .cmd          (push_cmd),
    .cmd_full     (cmd_full)
  );

  gbr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (push_cmd),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (pop_cmd),
    .empty   (cmd_empty)
  );

  gbr_back #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (pop_cmd),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .vert_w         (vert_w_r),
    .horiz_w        (horiz_w_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for the reflect-border Gaussian blur: scoreboard with a built-in predictor.
`timescale 1ns / 1ps
module testbench;
  import gbr_pkg::*;

  localparam int LIMIT = 1500000;
  localparam int R     = 2;
  localparam int MAXW  = 1024;

  // One expected output word
  typedef struct {
    pix_t pix;
    bit   run_last;
    bit   frame_last;
  } blur_word_t;

  // Predicts blurred words from accepted input words and checks results in order
  class blur_scoreboard;
    wgt_t             vert_w[3];
    wgt_t             horiz_w[3];
    logic [10:0]      frame_w;
    logic [10:0]      frame_h;
    pix_t             line_mem[4*MAXW];
    pix_t             win[5][5];
    int               col_cnt;
    int               row_cnt;
    blur_word_t       pending_q[$];
    int               errors;

    function void clear();
      vert_w  = '{16'd16474, 16'd14539, 16'd9992};
      horiz_w = '{16'd16474, 16'd14539, 16'd9992};
      frame_w = 11'd512;
      frame_h = 11'd512;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[k, a]) win[k][a] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_VERT_W0:  vert_w[0]  = data;
        CFG_VERT_W1:  vert_w[1]  = data;
        CFG_VERT_W2:  vert_w[2]  = data;
        CFG_HORIZ_W0: horiz_w[0] = data;
        CFG_HORIZ_W1: horiz_w[1] = data;
        CFG_HORIZ_W2: horiz_w[2] = data;
        CFG_WIDTH:    frame_w    = data[10:0];
        CFG_HEIGHT:   frame_h    = data[10:0];
        default: ;
      endcase
    endfunction

    function int width_used();
      return (frame_w < R + 1) ? R + 1 : (frame_w > MAXW) ? MAXW : int'(frame_w);
    endfunction

    function int height_used();
      return (frame_h < R + 1) ? R + 1 : (frame_h > 1024) ? 1024 : int'(frame_h);
    endfunction

    function int reflect(int q, int n);
      if (q < 0) q = -q;
      if (q > n - 1) q = 2 * (n - 1) - q;
      if (q < 0) q = 0;
      if (q > n - 1) q = n - 1;
      return q;
    endfunction

    function pix_t weighted_sum(int oc, int c, int w);
      longint unsigned acc;
      longint unsigned colsum;
      int k;
      acc = 0;
      for (int b = -R; b <= R; b++) begin
        k = c - reflect(oc + b, w);
        if (k < 0) k = 0;
        if (k > 2 * R) k = 2 * R;
        colsum = 0;
        for (int a = -R; a <= R; a++)
          colsum += longint'(vert_w[a < 0 ? -a : a]) * win[k][a + R];
        acc += longint'(horiz_w[b < 0 ? -b : b]) * colsum;
      end
      acc = (acc + 64'h8000_0000) >> 32;
      return (acc > 255) ? 8'hFF : acc[7:0];
    endfunction

    // Advance the model by one accepted input word
    function void note_input(bit op, pix_t px);
      int w, h, r, c, o, q, last;
      bit drain;
      blur_word_t wd;
      w = width_used();
      h = height_used();
      drain = row_cnt >= h;
      if (!drain && op) return;
      if (col_cnt > w - 1) col_cnt = w - 1;
      if (drain && row_cnt > h + R - 1) row_cnt = h + R - 1;
      r = row_cnt;
      c = col_cnt;
      o = r - R;
      if (o >= 0) begin
        for (int k = 4; k > 0; k--) win[k] = win[k - 1];
        for (int a = -R; a <= R; a++) begin
          q = reflect(o + a, h);
          win[0][a + R] = (!drain && q == r) ? px : line_mem[(q % 4) * MAXW + c];
        end
      end
      if (!drain) line_mem[(r % 4) * MAXW + c] = px;
      if (o >= 0 && c >= R) begin
        last = (c == w - 1) ? w - 1 : c - R;
        for (int oc = c - R; oc <= last; oc++) begin
          wd.pix        = weighted_sum(oc, c, w);
          wd.run_last   = (oc == last);
          wd.frame_last = drain && r == h + R - 1 && oc == w - 1;
          pending_q.push_back(wd);
        end
      end
      if (c == w - 1) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= h + R) row_cnt = 0;
      end else begin
        col_cnt++;
      end
    endfunction

    // Compare one accepted output word with the oldest expectation
    function void check_result(pix_t px, bit rl, bit fl);
      blur_word_t wd;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word pixel=%0d run_last=%0b frame_last=%0b",
                 $time, px, rl, fl);
        errors++;
        return;
      end
      wd = pending_q.pop_front();
      if (px !== wd.pix) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, wd.pix, px);
        errors++;
      end
      if (rl !== wd.run_last) begin
        $display("%0t: run_last expected %0b actual %0b", $time, wd.run_last, rl);
        errors++;
      end
      if (fl !== wd.frame_last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, wd.frame_last, fl);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_op;
  pix_t                 in_pixel_in;
  logic                 out_valid;
  logic                 out_stall;
  pix_t                 out_pixel_out;
  logic                 out_run_last;
  logic                 out_frame_last;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wr_data;

  blur_scoreboard sb;
  bit             idle_on;
  int             hold_left;
  int             cycles;

  gaussian_blur_reflect_border u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel_out(out_pixel_out),
    .out_run_last(out_run_last), .out_frame_last(out_frame_last),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  // Clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Accepted words on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_pixel_out, out_run_last, out_frame_last);
      if (in_valid && !in_stall) sb.note_input(in_op, in_pixel_in);
    end
  end

  // Receiver back-pressure: long hold-off on request, else random stalls while idling is on
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 27);
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_wr_en   = 1'b1;
    cfg_index   = idx;
    cfg_wr_data = data;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic send_word(bit op, pix_t px);
    while (idle_on && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_op       = op;
    in_pixel_in = px;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected word is out, plus pipeline slack
  task automatic drain_out();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_weights(wgt_t v0, wgt_t v1, wgt_t v2, wgt_t h0, wgt_t h1, wgt_t h2);
    cfg_write(CFG_VERT_W0, v0);
    cfg_write(CFG_VERT_W1, v1);
    cfg_write(CFG_VERT_W2, v2);
    cfg_write(CFG_HORIZ_W0, h0);
    cfg_write(CFG_HORIZ_W1, h1);
    cfg_write(CFG_HORIZ_W2, h2);
  endtask

  // One frame plus its flush; style 0 random, 1 black/white, 2 all white
  task automatic run_frame(int style);
    int   w, h;
    pix_t px;
    w = sb.width_used();
    h = sb.height_used();
    for (int i = 0; i < w * h; i++) begin
      // stray flush word inside the frame is ignored
      if ($urandom_range(99) < 4) send_word(1'b1, pix_t'($urandom));
      case (style)
        1:       px = (i % 2) ? 8'hFF : 8'h00;
        2:       px = 8'hFF;
        default: px = pix_t'($urandom);
      endcase
      send_word(1'b0, px);
    end
    // flush rows; a pixel word here counts as flush
    for (int i = 0; i < R * w; i++)
      send_word(($urandom_range(99) < 85), pix_t'($urandom));
  endtask

  initial begin
    sb          = new();
    sb.clear();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = 1'b0;
    in_pixel_in = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wr_data = '0;
    idle_on     = 1'b1;
    hold_left   = 0;
    cycles      = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    repeat (4) @(negedge clk);

    // Directed: default weights, sizes below the minimum clamp to 3x3
    set_weights(16'd16474, 16'd14539, 16'd9992, 16'd16474, 16'd14539, 16'd9992);
    cfg_write(CFG_WIDTH, 16'd0);
    cfg_write(CFG_HEIGHT, 16'd1);
    run_frame(1);
    drain_out();

    // Full-scale weights saturate the output
    set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    cfg_write(CFG_WIDTH, 16'd3);
    cfg_write(CFG_HEIGHT, 16'd3);
    run_frame(2);
    drain_out();

    // Zero weights, no idling on either side
    idle_on = 1'b0;
    set_weights(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    cfg_write(CFG_WIDTH, 16'd8);
    cfg_write(CFG_HEIGHT, 16'd4);
    run_frame(0);
    drain_out();
    idle_on = 1'b1;

    // Wider line, shortest frame
    set_weights(16'd16474, 16'd14539, 16'd9992, 16'd16474, 16'd14539, 16'd9992);
    cfg_write(CFG_WIDTH, 16'd8);
    cfg_write(CFG_HEIGHT, 16'd3);
    run_frame(0);
    drain_out();

    // Taller frame, narrowest line
    cfg_write(CFG_WIDTH, 16'd3);
    cfg_write(CFG_HEIGHT, 16'd10);
    run_frame(0);
    drain_out();

    // Long receiver hold-off while the sender keeps going
    cfg_write(CFG_WIDTH, 16'd8);
    cfg_write(CFG_HEIGHT, 16'd4);
    hold_left = 400;
    run_frame(0);
    drain_out();

    // Random weights and small sizes, back-to-back frames per setting
    for (int s = 0; s < 2; s++) begin
      set_weights(wgt_t'($urandom), wgt_t'($urandom), wgt_t'($urandom),
                  wgt_t'($urandom), wgt_t'($urandom), wgt_t'($urandom));
      cfg_write(CFG_WIDTH, 16'($urandom_range(5, 3)));
      cfg_write(CFG_HEIGHT, 16'($urandom_range(4, 3)));
      repeat (2) run_frame(0);
      drain_out();
    end

    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
